FILE: hw/rtl/ps2kbd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard decoder package
// Shared types, scan codes and the set 2 key table with its lookup function.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

	// Prefix bytes of scan code set 2.
	localparam logic [7:0] CODE_BREAK    = 8'hF0;
	localparam logic [7:0] CODE_EXTEND   = 8'hE0;

	// Modifier and lock key codes.
	localparam logic [7:0] CODE_LSHIFT   = 8'h12;
	localparam logic [7:0] CODE_RSHIFT   = 8'h59;
	localparam logic [7:0] CODE_CTRL     = 8'h14;
	localparam logic [7:0] CODE_CAPS     = 8'h58;
	localparam logic [7:0] CODE_SCROLL   = 8'h7E;
	localparam logic [7:0] CODE_NUM      = 8'h77;

	// Modifier held bits.
	localparam int MOD_LSHIFT = 0;
	localparam int MOD_RSHIFT = 1;
	localparam int MOD_LCTRL  = 2;
	localparam int MOD_RCTRL  = 3;

	// Lock bits.
	localparam int LOCK_CAPS   = 0;
	localparam int LOCK_NUM    = 1;
	localparam int LOCK_SCROLL = 2;

	// Lock state after reset: num lock on only.
	localparam logic [2:0] LOCK_RESET = 3'b010;

	// Side selection codes for shift and ctrl; left wins over right.
	localparam logic [1:0] SIDE_NONE  = 2'd0;
	localparam logic [1:0] SIDE_LEFT  = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;

	localparam int KEY_COUNT = 68;
	localparam int KEY_IDX_W = 7;

	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	// Decode phase of the prefix tracker.
	typedef enum logic [1:0] {
		PH_MAKE,
		PH_BREAK,
		PH_EXT_MAKE,
		PH_EXT_BREAK
	} phase_t;

	// Result of a key table search.
	typedef struct packed {
		logic     hit;
		key_idx_t index;
	} lookup_t;

	// Key table, in key index order.
	localparam logic [7:0] KEY_CODES [KEY_COUNT] = '{
		8'h1c, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2b, 8'h34, 8'h33, 8'h43, 8'h3b,
		8'h42, 8'h4b, 8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h2d, 8'h1b, 8'h2c,
		8'h3c, 8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a,
		8'h45, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e, 8'h46,
		8'h05, 8'h06, 8'h04, 8'h0c, 8'h03, 8'h0b, 8'h83, 8'h0a, 8'h01, 8'h09,
		8'h78, 8'h07,
		8'h29, 8'h71, 8'h52, 8'h55, 8'h41, 8'h4e, 8'h4a, 8'h4c, 8'h54, 8'h5d,
		8'h5b, 8'h75, 8'h72, 8'h6b, 8'h74, 8'h0d, 8'h76, 8'h37, 8'h5a, 8'h66
	};

	// Compare the code against every table entry in parallel; the lowest
	// matching position wins.
	function automatic lookup_t key_lookup(logic [7:0] code);
		lookup_t r;
		r.hit   = 1'b0;
		r.index = '0;
		for (int k = KEY_COUNT - 1; k >= 0; k--) begin
			if (KEY_CODES[k] == code) begin
				r.hit   = 1'b1;
				r.index = KEY_IDX_W'(k);
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/ps2_keyboard_scan_decoder.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard scan code decoder
// Decodes set 2 scan code bytes into key events with modifier and lock state.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream s_* carries one received scan code byte per item in
//   s_tdata[7:0]. The output stream m_* carries one key event per item for
//   each byte that completes a sequence naming a key in the key table;
//   prefixes, modifier keys, lock keys and unknown codes give no item.
//   A byte accepted into the input register is decoded from there, and its
//   event goes into the output register, which drives m_tvalid. One byte
//   is taken every cycle while s_tready is high; the decode state (prefix
//   phase, held modifiers, lock bits) is one register stage that is read
//   and updated by each byte as it leaves the input register.
//   When the receiver stalls, the event stays in the output register and
//   the next byte waits in the input register; s_tready drops only while
//   that waiting byte would produce another event. Bytes that produce no
//   event keep flowing. Reset clears both registers, puts the decoder in
//   the plain make phase with no modifiers held and num lock on.
// ----------------------------------------------------------------------------
module ps2_keyboard_scan_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] scan_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] key_index, [8:7] shift_mod,
	                               // [10:9] ctrl_mod, [13:11] lock_bits, zero fill
	output logic        m_tuser    // [0] key_down
);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Decode state.
	ps2kbd_pkg::phase_t phase_q, phase_d;
	logic [3:0]         mod_q, mod_d;
	logic [2:0]         lock_q, lock_d;

	// Result register.
	logic                 out_valid_q;
	ps2kbd_pkg::key_idx_t out_index_q;
	logic                 out_down_q;
	logic [1:0]           out_shift_q;
	logic [1:0]           out_ctrl_q;
	logic [2:0]           out_lock_q;

	ps2kbd_pkg::lookup_t look;
	logic                emit;
	logic                down;
	logic                hit;
	logic                adv;
	logic [1:0]          shift_sel;
	logic [1:0]          ctrl_sel;

	// The byte in the input register moves on unless it would produce an
	// event while the previous one is still waiting.
	assign adv      = valid_s1 && (!out_valid_q || m_tready || !hit);
	assign s_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Decode state registers, updated as each byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ps2kbd_pkg::PH_MAKE;
			mod_q   <= '0;
			lock_q  <= ps2kbd_pkg::LOCK_RESET;
		end else if (adv) begin
			phase_q <= phase_d;
			mod_q   <= mod_d;
			lock_q  <= lock_d;
		end
	end

	// Next state and event decision for the byte in the input register.
	always_comb begin
		phase_d = phase_q;
		mod_d   = mod_q;
		lock_d  = lock_q;
		emit    = 1'b0;
		down    = 1'b0;
		look    = ps2kbd_pkg::key_lookup(byte_s1);
		unique case (phase_q)
			ps2kbd_pkg::PH_MAKE: begin
				if (byte_s1 == ps2kbd_pkg::CODE_BREAK) begin
					phase_d = ps2kbd_pkg::PH_BREAK;
				end else if (byte_s1 == ps2kbd_pkg::CODE_EXTEND) begin
					phase_d = ps2kbd_pkg::PH_EXT_MAKE;
				end else begin
					phase_d = ps2kbd_pkg::PH_MAKE;
					unique case (byte_s1)
						ps2kbd_pkg::CODE_LSHIFT: mod_d[ps2kbd_pkg::MOD_LSHIFT] = 1'b1;
						ps2kbd_pkg::CODE_RSHIFT: mod_d[ps2kbd_pkg::MOD_RSHIFT] = 1'b1;
						ps2kbd_pkg::CODE_CTRL:   mod_d[ps2kbd_pkg::MOD_LCTRL]  = 1'b1;
						ps2kbd_pkg::CODE_CAPS: begin
							lock_d[ps2kbd_pkg::LOCK_CAPS] = !lock_q[ps2kbd_pkg::LOCK_CAPS];
						end
						ps2kbd_pkg::CODE_SCROLL: begin
							lock_d[ps2kbd_pkg::LOCK_SCROLL] =
								!lock_q[ps2kbd_pkg::LOCK_SCROLL];
						end
						ps2kbd_pkg::CODE_NUM: begin
							lock_d[ps2kbd_pkg::LOCK_NUM] = !lock_q[ps2kbd_pkg::LOCK_NUM];
						end
						default: begin
							emit = 1'b1;
							down = 1'b1;
						end
					endcase
				end
			end
			ps2kbd_pkg::PH_BREAK: begin
				if (byte_s1 == ps2kbd_pkg::CODE_BREAK ||
				    byte_s1 == ps2kbd_pkg::CODE_EXTEND) begin
					phase_d = ps2kbd_pkg::PH_BREAK;
				end else begin
					phase_d = ps2kbd_pkg::PH_MAKE;
					unique case (byte_s1)
						ps2kbd_pkg::CODE_LSHIFT: mod_d[ps2kbd_pkg::MOD_LSHIFT] = 1'b0;
						ps2kbd_pkg::CODE_RSHIFT: mod_d[ps2kbd_pkg::MOD_RSHIFT] = 1'b0;
						ps2kbd_pkg::CODE_CTRL:   mod_d[ps2kbd_pkg::MOD_LCTRL]  = 1'b0;
						default:                 emit = 1'b1;
					endcase
				end
			end
			ps2kbd_pkg::PH_EXT_MAKE: begin
				if (byte_s1 == ps2kbd_pkg::CODE_BREAK ||
				    byte_s1 == ps2kbd_pkg::CODE_EXTEND) begin
					phase_d = ps2kbd_pkg::PH_EXT_BREAK;
				end else begin
					phase_d = ps2kbd_pkg::PH_MAKE;
					if (byte_s1 == ps2kbd_pkg::CODE_CTRL) begin
						mod_d[ps2kbd_pkg::MOD_RCTRL] = 1'b1;
					end else begin
						emit = 1'b1;
						down = 1'b1;
					end
				end
			end
			ps2kbd_pkg::PH_EXT_BREAK: begin
				if (byte_s1 == ps2kbd_pkg::CODE_BREAK ||
				    byte_s1 == ps2kbd_pkg::CODE_EXTEND) begin
					phase_d = ps2kbd_pkg::PH_EXT_BREAK;
				end else begin
					phase_d = ps2kbd_pkg::PH_MAKE;
					if (byte_s1 == ps2kbd_pkg::CODE_CTRL) begin
						mod_d[ps2kbd_pkg::MOD_RCTRL] = 1'b0;
					end else begin
						emit = 1'b1;
					end
				end
			end
			default: begin
				phase_d = ps2kbd_pkg::PH_MAKE;
			end
		endcase
	end

	assign hit = emit && look.hit;

	// Shift and ctrl sides as seen before this byte; left wins over right.
	assign shift_sel = mod_q[ps2kbd_pkg::MOD_LSHIFT] ? ps2kbd_pkg::SIDE_LEFT :
	                   mod_q[ps2kbd_pkg::MOD_RSHIFT] ? ps2kbd_pkg::SIDE_RIGHT :
	                                                   ps2kbd_pkg::SIDE_NONE;
	assign ctrl_sel  = mod_q[ps2kbd_pkg::MOD_LCTRL]  ? ps2kbd_pkg::SIDE_LEFT :
	                   mod_q[ps2kbd_pkg::MOD_RCTRL]  ? ps2kbd_pkg::SIDE_RIGHT :
	                                                   ps2kbd_pkg::SIDE_NONE;

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && hit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (adv && hit) begin
			out_index_q <= look.index;
			out_down_q  <= down;
			out_shift_q <= shift_sel;
			out_ctrl_q  <= ctrl_sel;
			out_lock_q  <= lock_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_lock_q, out_ctrl_q, out_shift_q, out_index_q};
	assign m_tuser  = out_down_q;

`ifndef ASSERT_OFF
	// An event from the decoder always lands in the result register.
	a_event_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv && hit |=> m_tvalid)
		else $error("decoded key event did not reach the output register");

	// A new event appears only when a decoded byte produced one.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && hit))
		else $error("output event appeared without a decoded key");

	// Decode state moves only with a byte leaving the input register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(phase_q) && $stable(mod_q) && $stable(lock_q))
		else $error("decode state changed without a byte");

	// A pending event is never overwritten by the next decoded key.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |-> !(adv && hit))
		else $error("key event overwritten while output stalled");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PS/2 scan code decoder testbench
// Feeds set 2 scan code bytes into the decoder and compares every key event
// against a scan code tracker kept inside this bench. The tracker follows the
// prefix phase, held modifiers and lock bits. A short directed sequence
// covers the table ends, modifiers, locks and the odd prefix orders. Random
// make, break and extended sequences follow, with and without idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS  = 207;

	// One decoded key event, as it leaves the decoder.
	typedef struct packed {
		ps2kbd_pkg::key_idx_t idx;
		logic                 down;
		logic [1:0]           shift;
		logic [1:0]           ctrl;
		logic [2:0]           locks;
	} key_event_t;

	// One directed row: the byte, and a typed event where it is obvious.
	typedef struct packed {
		logic [7:0] code;
		logic       pinned;
		logic       pinned_has;
		key_event_t pinned_ev;
	} scan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;

	// Decoder state as tracked by the bench.
	ps2kbd_pkg::phase_t dec_phase;
	logic [3:0]         mods_held;
	logic [2:0]         lock_now;

	key_event_t  pending_events[$];
	int          error_count;
	int          idle_cycles;
	int          send_idle_pct;
	int          recv_idle_pct;

	ps2_keyboard_scan_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Advance the tracked decoder by one byte; returns 1 when a key event results.
	function automatic logic decode_byte(input logic [7:0] code, output key_event_t ev);
		logic is_prefix;
		logic look;
		logic down;
		logic hit;
		is_prefix = (code == ps2kbd_pkg::CODE_BREAK) || (code == ps2kbd_pkg::CODE_EXTEND);
		look = 1'b0;
		down = 1'b0;
		hit  = 1'b0;
		ev   = '0;
		case (dec_phase)
			ps2kbd_pkg::PH_MAKE: begin
				if (code == ps2kbd_pkg::CODE_BREAK) begin
					dec_phase = ps2kbd_pkg::PH_BREAK;
				end else if (code == ps2kbd_pkg::CODE_EXTEND) begin
					dec_phase = ps2kbd_pkg::PH_EXT_MAKE;
				end else begin
					dec_phase = ps2kbd_pkg::PH_MAKE;
					if (code == ps2kbd_pkg::CODE_LSHIFT)
						mods_held[ps2kbd_pkg::MOD_LSHIFT] = 1'b1;
					else if (code == ps2kbd_pkg::CODE_RSHIFT)
						mods_held[ps2kbd_pkg::MOD_RSHIFT] = 1'b1;
					else if (code == ps2kbd_pkg::CODE_CTRL)
						mods_held[ps2kbd_pkg::MOD_LCTRL] = 1'b1;
					else if (code == ps2kbd_pkg::CODE_CAPS)
						lock_now[ps2kbd_pkg::LOCK_CAPS] = ~lock_now[ps2kbd_pkg::LOCK_CAPS];
					else if (code == ps2kbd_pkg::CODE_SCROLL)
						lock_now[ps2kbd_pkg::LOCK_SCROLL] = ~lock_now[ps2kbd_pkg::LOCK_SCROLL];
					else if (code == ps2kbd_pkg::CODE_NUM)
						lock_now[ps2kbd_pkg::LOCK_NUM] = ~lock_now[ps2kbd_pkg::LOCK_NUM];
					else begin
						look = 1'b1;
						down = 1'b1;
					end
				end
			end
			ps2kbd_pkg::PH_BREAK: begin
				if (!is_prefix) begin
					dec_phase = ps2kbd_pkg::PH_MAKE;
					if (code == ps2kbd_pkg::CODE_LSHIFT)
						mods_held[ps2kbd_pkg::MOD_LSHIFT] = 1'b0;
					else if (code == ps2kbd_pkg::CODE_RSHIFT)
						mods_held[ps2kbd_pkg::MOD_RSHIFT] = 1'b0;
					else if (code == ps2kbd_pkg::CODE_CTRL)
						mods_held[ps2kbd_pkg::MOD_LCTRL] = 1'b0;
					else look = 1'b1;
				end
			end
			ps2kbd_pkg::PH_EXT_MAKE: begin
				if (is_prefix) begin
					dec_phase = ps2kbd_pkg::PH_EXT_BREAK;
				end else begin
					dec_phase = ps2kbd_pkg::PH_MAKE;
					if (code == ps2kbd_pkg::CODE_CTRL) mods_held[ps2kbd_pkg::MOD_RCTRL] = 1'b1;
					else begin
						look = 1'b1;
						down = 1'b1;
					end
				end
			end
			default: begin
				if (!is_prefix) begin
					dec_phase = ps2kbd_pkg::PH_MAKE;
					if (code == ps2kbd_pkg::CODE_CTRL) mods_held[ps2kbd_pkg::MOD_RCTRL] = 1'b0;
					else look = 1'b1;
				end
			end
		endcase

		// Key table search; the first matching position gives the index.
		if (look) begin
			for (int k = 0; k < ps2kbd_pkg::KEY_COUNT; k++) begin
				if (!hit && ps2kbd_pkg::KEY_CODES[k] == code) begin
					hit = 1'b1;
					ev.idx = ps2kbd_pkg::key_idx_t'(k);
				end
			end
		end
		if (hit) begin
			ev.down  = down;
			ev.shift = mods_held[ps2kbd_pkg::MOD_LSHIFT] ? ps2kbd_pkg::SIDE_LEFT :
			           (mods_held[ps2kbd_pkg::MOD_RSHIFT] ? ps2kbd_pkg::SIDE_RIGHT :
			                                                ps2kbd_pkg::SIDE_NONE);
			ev.ctrl  = mods_held[ps2kbd_pkg::MOD_LCTRL] ? ps2kbd_pkg::SIDE_LEFT :
			           (mods_held[ps2kbd_pkg::MOD_RCTRL] ? ps2kbd_pkg::SIDE_RIGHT :
			                                               ps2kbd_pkg::SIDE_NONE);
			ev.locks = lock_now;
		end
		return hit;
	endfunction

	// Offer one byte, wait for it to be taken, then record the expected event.
	task automatic send_byte(input logic [7:0] code, input logic pinned,
	                         input logic pinned_has, input key_event_t pinned_ev);
		key_event_t ev;
		logic       hit;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
		hit = decode_byte(code, ev);
		if (pinned) begin
			hit = pinned_has;
			ev  = pinned_ev;
		end
		if (hit) pending_events.push_back(ev);
	endtask

	// Hold the sender until every expected event has come out.
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) @(posedge clk);
	endtask

	// Pick a scan code, biased toward table keys and modifiers.
	function automatic logic [7:0] pick_code();
		int sel;
		sel = $urandom_range(99);
		if (sel < 60) return ps2kbd_pkg::KEY_CODES[$urandom_range(ps2kbd_pkg::KEY_COUNT - 1)];
		if (sel < 67) return ps2kbd_pkg::CODE_LSHIFT;
		if (sel < 72) return ps2kbd_pkg::CODE_RSHIFT;
		if (sel < 78) return ps2kbd_pkg::CODE_CTRL;
		if (sel < 81) return ps2kbd_pkg::CODE_CAPS;
		if (sel < 84) return ps2kbd_pkg::CODE_NUM;
		if (sel < 87) return ps2kbd_pkg::CODE_SCROLL;
		return 8'($urandom_range(255));
	endfunction

	// Receiver: compare each event with the oldest expectation, stall at random.
	always @(posedge clk) begin
		key_event_t got;
		key_event_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.idx   = m_tdata[6:0];
				got.shift = m_tdata[8:7];
				got.ctrl  = m_tdata[10:9];
				got.locks = m_tdata[13:11];
				got.down  = m_tuser;
				if (pending_events.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display({"unexpected key event: idx=%0d down=%0d",
						          " shift=%0d ctrl=%0d lock=%b"},
						         got.idx, got.down, got.shift, got.ctrl, got.locks);
				end else begin
					want = pending_events.pop_front();
					if (got != want || m_tdata[15:14] != 2'b00) begin
						error_count++;
						if (error_count <= 10)
							$display({"key event mismatch: expected idx=%0d down=%0d shift=%0d",
							          " ctrl=%0d lock=%b, got idx=%0d down=%0d shift=%0d",
							          " ctrl=%0d lock=%b fill=%b"},
							         want.idx, want.down, want.shift, want.ctrl, want.locks,
							         got.idx, got.down, got.shift, got.ctrl, got.locks,
							         m_tdata[15:14]);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: too many cycles in a row with no item moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired with %0d events outstanding",
				         pending_events.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		scan_row_t  dir_rows[28];
		logic [7:0] seq[$];
		int         sent;
		int         kind;
		int         runs;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		m_tready      = 1'b0;
		error_count   = 0;
		idle_cycles   = 0;
		dec_phase     = ps2kbd_pkg::PH_MAKE;
		mods_held     = '0;
		lock_now      = ps2kbd_pkg::LOCK_RESET;
		send_idle_pct = 11;
		recv_idle_pct = 66;

		// Directed sequence: table ends, both shifts and ctrls, prefix runs, locks.
		dir_rows = '{
			'{8'h1C, 1'b1, 1'b1, '{7'd0, 1'b1, ps2kbd_pkg::SIDE_NONE,
			                       ps2kbd_pkg::SIDE_NONE, ps2kbd_pkg::LOCK_RESET}},
			'{8'h66, 1'b1, 1'b1, '{7'd67, 1'b1, ps2kbd_pkg::SIDE_NONE,
			                       ps2kbd_pkg::SIDE_NONE, ps2kbd_pkg::LOCK_RESET}},
			'{ps2kbd_pkg::CODE_BREAK, 1'b1, 1'b0, '0},
			'{8'h66, 1'b1, 1'b1, '{7'd67, 1'b0, ps2kbd_pkg::SIDE_NONE,
			                       ps2kbd_pkg::SIDE_NONE, ps2kbd_pkg::LOCK_RESET}},
			'{8'h00, 1'b1, 1'b0, '0},
			'{8'hFF, 1'b1, 1'b0, '0},
			'{ps2kbd_pkg::CODE_LSHIFT, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_RSHIFT, 1'b0, 1'b0, '0},
			'{8'h2C, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_BREAK, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_LSHIFT, 1'b0, 1'b0, '0},
			'{8'h1D, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_CTRL, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_EXTEND, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_CTRL, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_BREAK, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_EXTEND, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_CTRL, 1'b0, 1'b0, '0},
			'{8'h83, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_EXTEND, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_BREAK, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_EXTEND, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_CTRL, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_CAPS, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_SCROLL, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_NUM, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_BREAK, 1'b0, 1'b0, '0},
			'{ps2kbd_pkg::CODE_CAPS, 1'b0, 1'b0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_byte(dir_rows[i].code, dir_rows[i].pinned, dir_rows[i].pinned_has,
			          dir_rows[i].pinned_ev);
		drain_events();

		// Random sequences in three idle patterns, drained between patterns.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 11 : ((ph == 1) ? 66 : 0);
			recv_idle_pct = (ph == 0) ? 66 : ((ph == 1) ? 11 : 0);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				seq.delete();
				kind = $urandom_range(99);
				if (kind < 8) begin
					// Noise: a lone random byte, which may itself be a prefix.
					seq.push_back(8'($urandom_range(255)));
				end else if (kind < 18) begin
					// Broken sequence: a run of mixed prefixes before the code.
					runs = $urandom_range(1, 3);
					repeat (runs)
						seq.push_back($urandom_range(1) ? ps2kbd_pkg::CODE_BREAK :
						                                  ps2kbd_pkg::CODE_EXTEND);
					seq.push_back(pick_code());
				end else begin
					case ($urandom_range(3))
						0: ;
						1: seq.push_back(ps2kbd_pkg::CODE_BREAK);
						2: seq.push_back(ps2kbd_pkg::CODE_EXTEND);
						default: begin
							seq.push_back(ps2kbd_pkg::CODE_EXTEND);
							seq.push_back(ps2kbd_pkg::CODE_BREAK);
						end
					endcase
					seq.push_back(pick_code());
				end
				foreach (seq[j]) send_byte(seq[j], 1'b0, 1'b0, '0);
				sent += seq.size();
			end
			drain_events();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_events.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
